/* rtl/rmth_pkg.sv */
// Shared types, constants and the heap ordering function for the running median block.
`timescale 1ns / 1ps

package rmth_pkg;

  localparam int unsigned SampleW = 32;
  localparam int unsigned MedW    = 33;

  typedef logic signed [SampleW-1:0] sample_t;
  typedef logic signed [MedW-1:0]    median_t;

  // Lower half is a max-heap, upper half a min-heap
  typedef enum logic {
    HeapLower = 1'b0,
    HeapUpper = 1'b1
  } heap_e;

  // Push appends and sifts up; replace overwrites the root and sifts down
  typedef enum logic {
    OpPush    = 1'b0,
    OpReplace = 1'b1
  } op_e;

  typedef struct packed {
    op_e     op;
    heap_e   heap;
    sample_t value;
  } sift_cmd_t;

  // Write to the root of one heap, so the top level can track both tops
  typedef struct packed {
    logic    valid;
    heap_e   heap;
    sample_t value;
  } root_wr_t;

  // True when a belongs nearer the root than b in the given heap
  function automatic logic outranks(sample_t a, sample_t b, heap_e heap);
    logic res;
    if (heap == HeapLower) begin
      res = (a > b);
    end else begin
      res = (a < b);
    end
    return res;
  endfunction

endpackage

/* rtl/rmth_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module rmth_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/rmth_sift.sv */
// Heap sift engine: one comparator and one heap RAM stepped by a small sequencer.
`timescale 1ns / 1ps

module rmth_sift #(
  parameter int unsigned IW = 9
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  rmth_pkg::sift_cmd_t  cmd_i,
  input  logic [IW:0]          size_i,
  output logic                 busy_o,
  output logic                 done_o,
  output rmth_pkg::root_wr_t   root_wr_o
);

  localparam int unsigned AW = IW + 1;
  localparam int unsigned XW = IW + 2;

  localparam logic [2:0] ST_IDLE    = 3'd0;
  localparam logic [2:0] ST_UP_RD   = 3'd1;
  localparam logic [2:0] ST_UP_CMP  = 3'd2;
  localparam logic [2:0] ST_DN_RDL  = 3'd3;
  localparam logic [2:0] ST_DN_RDR  = 3'd4;
  localparam logic [2:0] ST_DN_PICK = 3'd5;
  localparam logic [2:0] ST_DN_CMP  = 3'd6;

  logic [2:0]        state_q, state_d;
  rmth_pkg::heap_e   heap_q, heap_d;
  rmth_pkg::sample_t val_q, val_d;
  rmth_pkg::sample_t hl_q, hl_d;
  rmth_pkg::sample_t hc_q, hc_d;
  logic [IW:0]       size_q, size_d;
  logic [IW-1:0]     idx_q, idx_d;
  logic [IW-1:0]     cidx_q, cidx_d;

  logic [XW-1:0]     idx_x, l_x, r_x, size_x;
  logic              has_l, has_r;
  logic [IW-1:0]     parent;

  rmth_pkg::sample_t cmp_a, cmp_b;
  logic              cmp_win;

  logic              we;
  logic [IW-1:0]     widx;
  rmth_pkg::sample_t wdata;
  logic [IW-1:0]     ridx;
  logic [31:0]       rdata_raw;
  rmth_pkg::sample_t rdata;
  logic              fin;

  // Child and parent positions of the current hole
  assign idx_x  = XW'(idx_q);
  assign l_x    = (idx_x << 1) + XW'(1);
  assign r_x    = l_x + XW'(1);
  assign size_x = XW'(size_q);
  assign has_l  = (l_x < size_x);
  assign has_r  = (r_x < size_x);
  assign parent = IW'((idx_q - IW'(1)) >> 1);

  assign rdata = rmth_pkg::sample_t'(rdata_raw);

  // Shared comparator, operands chosen by sequencer step
  always_comb begin
    unique case (state_q)
      ST_UP_CMP: begin
        cmp_a = val_q;
        cmp_b = rdata;
      end
      ST_DN_PICK: begin
        cmp_a = rdata;
        cmp_b = hl_q;
      end
      default: begin
        cmp_a = hc_q;
        cmp_b = val_q;
      end
    endcase
  end

  assign cmp_win = rmth_pkg::outranks(cmp_a, cmp_b, heap_q);

  // Sequencer
  always_comb begin
    state_d = state_q;
    heap_d  = heap_q;
    val_d   = val_q;
    hl_d    = hl_q;
    hc_d    = hc_q;
    size_d  = size_q;
    idx_d   = idx_q;
    cidx_d  = cidx_q;
    we      = 1'b0;
    widx    = idx_q;
    wdata   = val_q;
    ridx    = idx_q;
    fin     = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          heap_d = cmd_i.heap;
          val_d  = cmd_i.value;
          size_d = size_i;
          if (cmd_i.op == rmth_pkg::OpPush) begin
            idx_d   = size_i[IW-1:0];
            state_d = ST_UP_RD;
          end else begin
            idx_d   = '0;
            state_d = ST_DN_RDL;
          end
        end
      end
      ST_UP_RD: begin
        if (idx_q == '0) begin
          we      = 1'b1;
          fin     = 1'b1;
          state_d = ST_IDLE;
        end else begin
          ridx    = parent;
          state_d = ST_UP_CMP;
        end
      end
      ST_UP_CMP: begin
        we = 1'b1;
        if (cmp_win) begin
          // parent moves down into the hole
          wdata   = rdata;
          idx_d   = parent;
          state_d = ST_UP_RD;
        end else begin
          fin     = 1'b1;
          state_d = ST_IDLE;
        end
      end
      ST_DN_RDL: begin
        if (!has_l) begin
          we      = 1'b1;
          fin     = 1'b1;
          state_d = ST_IDLE;
        end else begin
          ridx    = l_x[IW-1:0];
          state_d = ST_DN_RDR;
        end
      end
      ST_DN_RDR: begin
        hl_d = rdata;
        if (has_r) begin
          ridx = r_x[IW-1:0];
        end
        state_d = ST_DN_PICK;
      end
      ST_DN_PICK: begin
        if (has_r && cmp_win) begin
          hc_d   = rdata;
          cidx_d = r_x[IW-1:0];
        end else begin
          hc_d   = hl_q;
          cidx_d = l_x[IW-1:0];
        end
        state_d = ST_DN_CMP;
      end
      ST_DN_CMP: begin
        we = 1'b1;
        if (cmp_win) begin
          // better child moves up into the hole
          wdata   = hc_q;
          idx_d   = cidx_q;
          state_d = ST_DN_RDL;
        end else begin
          fin     = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    heap_q <= heap_d;
    val_q  <= val_d;
    hl_q   <= hl_d;
    hc_q   <= hc_d;
    size_q <= size_d;
    idx_q  <= idx_d;
    cidx_q <= cidx_d;
  end

  // Both heaps share one RAM, heap select on the top address bit
  rmth_ram #(
    .WIDTH (rmth_pkg::SampleW),
    .DEPTH (2 ** AW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i ({heap_q, widx}),
    .wdata_i (wdata),
    .raddr_i ({heap_q, ridx}),
    .rdata_o (rdata_raw)
  );

  assign busy_o          = (state_q != ST_IDLE);
  assign done_o          = fin;
  assign root_wr_o.valid = we && (widx == '0);
  assign root_wr_o.heap  = heap_q;
  assign root_wr_o.value = wdata;

endmodule

/* rtl/running_median_two_heaps.sv */
// Running median top level: step control, heap tops, counts and result register.
//
// Input channel: sample_i with in_valid_i / in_stall_o. Output channel:
// median_doubled_o, count_o, dropped_o with out_valid_o / out_stall_i.
// Each accepted sample yields exactly one result beat: twice the median
// of all samples held (sum of the two middles when the count is even),
// the number held, and a drop flag set when CAPACITY samples were already
// held, in which case the sample is discarded and the median repeats.
// One sample is handled at a time: the control steps decide, run one
// or two heap sifts and register the result. A sift-up reads one parent
// per level, a sift-down reads both children per level, over up to
// log2(CAPACITY/2) levels. The single read port of the heap RAM and the
// one shared comparator set the pace of each sift.
// in_stall_o is high from acceptance until the result is registered.
// A finished result waits in the output register while the receiver
// stalls; the next sample is taken meanwhile and its result waits behind.
// Reset clears both heap counts and the output valid; heap storage is
// not cleared, only entries below the counts are ever read.
`timescale 1ns / 1ps

module running_median_two_heaps #(
  parameter int unsigned CAPACITY = 1024
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic signed [rmth_pkg::SampleW-1:0]  sample_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic signed [rmth_pkg::MedW-1:0]     median_doubled_o,
  output logic [$clog2(CAPACITY+1)-1:0]        count_o,
  output logic                                 dropped_o
);

  localparam int unsigned HD   = (CAPACITY + 1) / 2;
  localparam int unsigned IW   = (HD > 1) ? $clog2(HD) : 1;
  localparam int unsigned NW   = IW + 1;
  localparam int unsigned CNTW = $clog2(CAPACITY + 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DEC  = 3'd1;
  localparam logic [2:0] S_RUN1 = 3'd2;
  localparam logic [2:0] S_ST2  = 3'd3;
  localparam logic [2:0] S_RUN2 = 3'd4;
  localparam logic [2:0] S_FIN  = 3'd5;

  logic [2:0]          state_q, state_d;
  logic [NW-1:0]       lower_q, lower_d;
  logic [NW-1:0]       upper_q, upper_d;
  rmth_pkg::sample_t   sample_q;
  rmth_pkg::sample_t   lower_top_q, upper_top_q;
  logic                drop_q, drop_d;
  logic                has2_q, has2_d;
  rmth_pkg::sift_cmd_t op2_q, op2_d;
  logic [NW-1:0]       size2_q, size2_d;

  logic                out_valid_q;
  rmth_pkg::median_t   median_q;
  logic [CNTW-1:0]     count_q;
  logic                dropped_q;

  logic                start;
  rmth_pkg::sift_cmd_t cmd;
  logic [NW-1:0]       size;
  rmth_pkg::sift_cmd_t op1;
  logic [NW-1:0]       size1;
  logic                busy;
  logic                done;
  rmth_pkg::root_wr_t  root_wr;

  logic [CNTW-1:0]     total;
  logic                full;
  logic                even;
  rmth_pkg::median_t   lo_x, up_x, median;
  logic                load_out;

  assign total = CNTW'(lower_q) + CNTW'(upper_q);
  assign full  = ({1'b0, total} >= (CNTW + 1)'(CAPACITY));
  assign even  = (lower_q == upper_q);

  // Plan: at most one replace-root sift, then one push
  always_comb begin
    lower_d       = lower_q;
    upper_d       = upper_q;
    has2_d        = 1'b0;
    op1.op        = rmth_pkg::OpPush;
    op1.heap      = rmth_pkg::HeapLower;
    op1.value     = sample_q;
    size1         = lower_q;
    op2_d.op      = rmth_pkg::OpPush;
    op2_d.heap    = rmth_pkg::HeapLower;
    op2_d.value   = upper_top_q;
    size2_d       = lower_q;
    if (even) begin
      lower_d = lower_q + NW'(1);
      if ((lower_q != '0) &&
          rmth_pkg::outranks(sample_q, upper_top_q, rmth_pkg::HeapLower)) begin
        // sample belongs above: swap it for the upper top
        op1.op   = rmth_pkg::OpReplace;
        op1.heap = rmth_pkg::HeapUpper;
        size1    = upper_q;
        has2_d   = 1'b1;
      end
    end else begin
      upper_d    = upper_q + NW'(1);
      op1.heap   = rmth_pkg::HeapUpper;
      size1      = upper_q;
      op2_d.heap = rmth_pkg::HeapUpper;
      op2_d.value = lower_top_q;
      size2_d    = upper_q;
      if (rmth_pkg::outranks(sample_q, lower_top_q, rmth_pkg::HeapUpper)) begin
        // sample belongs below: swap it for the lower top
        op1.op   = rmth_pkg::OpReplace;
        op1.heap = rmth_pkg::HeapLower;
        size1    = lower_q;
        has2_d   = 1'b1;
      end
    end
  end

  // Step control
  always_comb begin
    state_d = state_q;
    drop_d  = drop_q;
    start   = 1'b0;
    cmd     = op1;
    size    = size1;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_DEC;
        end
      end
      S_DEC: begin
        drop_d = full;
        if (full) begin
          state_d = S_FIN;
        end else begin
          start   = 1'b1;
          state_d = S_RUN1;
        end
      end
      S_RUN1: begin
        if (done) begin
          state_d = has2_q ? S_ST2 : S_FIN;
        end
      end
      S_ST2: begin
        start   = 1'b1;
        cmd     = op2_q;
        size    = size2_q;
        state_d = S_RUN2;
      end
      S_RUN2: begin
        if (done) begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        if (load_out) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      lower_q <= '0;
      upper_q <= '0;
    end else begin
      state_q <= state_d;
      if ((state_q == S_DEC) && !full) begin
        lower_q <= lower_d;
        upper_q <= upper_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    drop_q <= drop_d;
    if ((state_q == S_IDLE) && in_valid_i) begin
      sample_q <= sample_i;
    end
    if (state_q == S_DEC) begin
      has2_q  <= has2_d;
      op2_q   <= op2_d;
      size2_q <= size2_d;
    end
    // track heap roots as the engine writes them
    if (root_wr.valid) begin
      if (root_wr.heap == rmth_pkg::HeapLower) begin
        lower_top_q <= root_wr.value;
      end else begin
        upper_top_q <= root_wr.value;
      end
    end
  end

  rmth_sift #(
    .IW (IW)
  ) u_sift (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (start),
    .cmd_i     (cmd),
    .size_i    (size),
    .busy_o    (busy),
    .done_o    (done),
    .root_wr_o (root_wr)
  );

  // Doubled median from the two tops
  assign lo_x = rmth_pkg::median_t'(lower_top_q);
  assign up_x = rmth_pkg::median_t'(upper_top_q);

  always_comb begin
    if (lower_q == '0) begin
      median = '0;
    end else if ((lower_q > upper_q) || (upper_q == '0)) begin
      median = lo_x + lo_x;
    end else begin
      median = lo_x + up_x;
    end
  end

  // Result register
  assign load_out = (state_q == S_FIN) && (!out_valid_q || !out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      median_q  <= median;
      count_q   <= total;
      dropped_q <= drop_q;
    end
  end

  assign in_stall_o       = (state_q != S_IDLE);
  assign out_valid_o      = out_valid_q;
  assign median_doubled_o = median_q;
  assign count_o          = count_q;
  assign dropped_o        = dropped_q;

  // Checks
  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start |-> !busy)
    else $error("sift started while engine busy");

  a_balance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (lower_q == upper_q) || (lower_q == upper_q + NW'(1)))
    else $error("heap sizes out of balance");

  a_done_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done |-> ((state_q == S_RUN1) || (state_q == S_RUN2)))
    else $error("sift finished outside a run step");

  a_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ({1'b0, total} <= (CNTW + 1)'(CAPACITY)))
    else $error("sample count above capacity");

endmodule
